/* rtl/rkg_pkg.sv */
package rkg_pkg;

    localparam int BANDS = 58;
    localparam int KEYS = 6;
    localparam int NREGS = 6;

    localparam int BAND_W = 6;
    localparam int KEY_W = 3;
    localparam int REG_W = 3;
    localparam int COLOUR_W = 12;
    localparam int CHAN_W = 4;
    localparam int DELTA_W = 5;
    localparam int LEN_W = 6;
    localparam int LAG_W = 12;

    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [NREGS-1:0][COLOUR_W-1:0] key_bank_t;
    // element 0 is red, 1 green, 2 blue
    typedef logic [2:0][CHAN_W-1:0] chans_t;
    typedef logic [2:0][DELTA_W-1:0] deltas_t;

    localparam key_bank_t KEY_RESET = {
        12'hFFB, 12'hF84, 12'hB5A, 12'h54C, 12'h138, 12'h000
    };

    // walker position seen by the segment finder
    typedef struct packed {
        chans_t           chans;
        logic [KEY_W-1:0] target;
    } pos_t;

    // next non-empty segment, from the segment finder
    typedef struct packed {
        logic             scan;
        logic             found;
        logic [KEY_W-1:0] target;
        deltas_t          deltas;
        logic [LEN_W-1:0] len;
    } seg_t;

    typedef struct packed {
        colour_t           colour;
        logic [BAND_W-1:0] index;
        logic              last;
    } band_t;

    function automatic chans_t colour_to_chans(input colour_t colour);
        chans_t ch;
        ch[0] = colour[11:8];
        ch[1] = colour[7:4];
        ch[2] = colour[3:0];
        return ch;
    endfunction

    function automatic colour_t chans_to_colour(input chans_t ch);
        return {ch[0], ch[1], ch[2]};
    endfunction

    // keys past the register bank read the last register
    function automatic logic [REG_W-1:0] key_at(input logic [KEY_W-1:0] k);
        logic [REG_W-1:0] idx;
        if (4'(k) < 4'(NREGS))
            idx = REG_W'(k);
        else
            idx = REG_W'(NREGS - 1);
        return idx;
    endfunction

    function automatic logic [CHAN_W-1:0] delta_mag(input logic [DELTA_W-1:0] d);
        logic [DELTA_W-1:0] m;
        m = d[DELTA_W-1] ? (~d + DELTA_W'(1)) : d;
        return m[CHAN_W-1:0];
    endfunction

endpackage

/* rtl/rkg_ifs.sv */
interface rkg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface rkg_band_if;
    logic                          valid;
    logic                          ready;
    logic [rkg_pkg::COLOUR_W-1:0]  band_colour;
    logic [rkg_pkg::BAND_W-1:0]    band_index;
    logic                          last_band;

    modport source (output valid, output band_colour, output band_index,
                    output last_band, input ready);
    modport sink (input valid, input band_colour, input band_index,
                  input last_band, output ready);
endinterface

interface rkg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rkg_pkg::REG_W-1:0]     index;
    logic [rkg_pkg::COLOUR_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/rkg_keys.sv */
module rkg_keys (
    input  logic               clk,
    input  logic               rst_n,
    rkg_cfg_if.sink            cfg,
    output rkg_pkg::key_bank_t keys
);

    rkg_pkg::key_bank_t keys_reg;

    assign cfg.ready = 1'b1;
    assign keys = keys_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg <= rkg_pkg::KEY_RESET;
        end
        else if (cfg.valid && (4'(cfg.index) < 4'(rkg_pkg::NREGS)))
        begin
            keys_reg[cfg.index] <= cfg.data;
        end
    end

endmodule

/* rtl/rkg_seg_find.sv */
module rkg_seg_find (
    input  rkg_pkg::key_bank_t keys,
    input  rkg_pkg::pos_t      pos,
    output rkg_pkg::seg_t      seg
);

    rkg_pkg::colour_t             cur_colour;
    rkg_pkg::colour_t             sel_key;
    rkg_pkg::chans_t              sel_chans;
    logic [rkg_pkg::KEY_W-1:0]    sel_idx;
    logic                         found;
    logic [rkg_pkg::LEN_W-1:0]    len;
    rkg_pkg::deltas_t             deltas;

    assign cur_colour = rkg_pkg::chans_to_colour(pos.chans);

    // first key after the target that differs from the current colour;
    // equal keys are empty segments and get skipped
    always_comb
    begin
        found = 1'b0;
        sel_idx = '0;
        for (int k = rkg_pkg::KEYS - 1; k >= 0; k--)
        begin
            if ((rkg_pkg::KEY_W'(k) > pos.target)
                && (keys[rkg_pkg::key_at(rkg_pkg::KEY_W'(k))] != cur_colour))
            begin
                found = 1'b1;
                sel_idx = rkg_pkg::KEY_W'(k);
            end
        end
    end

    assign sel_key = keys[rkg_pkg::key_at(sel_idx)];
    assign sel_chans = rkg_pkg::colour_to_chans(sel_key);

    always_comb
    begin
        len = '0;
        for (int c = 0; c < 3; c++)
        begin
            deltas[c] = {1'b0, sel_chans[c]} - {1'b0, pos.chans[c]};
            len = len + rkg_pkg::LEN_W'(rkg_pkg::delta_mag(deltas[c]));
        end
    end

    always_comb
    begin
        seg.scan = ((4'(pos.target) + 4'd1) < 4'(rkg_pkg::KEYS));
        seg.found = found;
        seg.target = sel_idx;
        seg.deltas = deltas;
        seg.len = len;
    end

endmodule

/* rtl/rkg_core.sv */
module rkg_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               restart,
    input  rkg_pkg::key_bank_t keys,
    input  rkg_pkg::seg_t      seg,
    output rkg_pkg::pos_t      pos,
    output rkg_pkg::band_t     result
);

    localparam int T_W = rkg_pkg::LEN_W + 1;

    rkg_pkg::chans_t                chans_reg, chans_next;
    rkg_pkg::deltas_t               deltas_reg, deltas_next;
    rkg_pkg::chans_t                moved_reg, moved_next;
    logic [rkg_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [rkg_pkg::LEN_W-1:0]      step_reg, step_next;
    logic [rkg_pkg::KEY_W-1:0]      target_reg, target_next;
    logic [rkg_pkg::BAND_W-1:0]     band_cnt_reg, band_cnt_next;

    logic [rkg_pkg::BAND_W-1:0]     band;
    logic                           last;
    logic                           do_walk;
    rkg_pkg::deltas_t               w_deltas;
    rkg_pkg::chans_t                w_moved;
    logic [rkg_pkg::LEN_W-1:0]      w_len;
    logic [rkg_pkg::LEN_W-1:0]      w_step;
    logic [T_W-1:0]                 t;
    logic [rkg_pkg::CHAN_W-1:0]     mag [3];
    logic signed [rkg_pkg::LAG_W-1:0] lag [3];
    logic signed [rkg_pkg::LAG_W-1:0] best_lag;
    logic                           have_best;
    logic [1:0]                     best;

    assign pos.chans = chans_reg;
    assign pos.target = target_reg;

    // lag of each channel on the working segment
    always_comb
    begin
        t = T_W'(w_step) + T_W'(1);
        for (int c = 0; c < 3; c++)
        begin
            mag[c] = rkg_pkg::delta_mag(w_deltas[c]);
            lag[c] = $signed(rkg_pkg::LAG_W'(mag[c]) * rkg_pkg::LAG_W'(t))
                   - $signed(rkg_pkg::LAG_W'(w_moved[c]) * rkg_pkg::LAG_W'(w_len));
        end
        have_best = 1'b0;
        best_lag = '0;
        best = 2'd0;
        for (int c = 0; c < 3; c++)
        begin
            if ((w_moved[c] != mag[c]) && (!have_best || (lag[c] > best_lag)))
            begin
                have_best = 1'b1;
                best_lag = lag[c];
                best = 2'(c);
            end
        end
    end

    always_comb
    begin
        chans_next = chans_reg;
        deltas_next = deltas_reg;
        moved_next = moved_reg;
        len_next = len_reg;
        step_next = step_reg;
        target_next = target_reg;
        do_walk = 1'b0;
        w_deltas = deltas_reg;
        w_moved = moved_reg;
        w_len = len_reg;
        w_step = step_reg;

        band = restart ? '0 : band_cnt_reg;
        last = (band >= rkg_pkg::BAND_W'(rkg_pkg::BANDS - 1));
        band_cnt_next = last ? '0 : band + rkg_pkg::BAND_W'(1);

        if (band == '0)
        begin
            chans_next = rkg_pkg::colour_to_chans(keys[0]);
            deltas_next = '0;
            moved_next = '0;
            len_next = '0;
            step_next = '0;
            target_next = '0;
        end
        else if (step_reg < len_reg)
        begin
            do_walk = 1'b1;
        end
        else if (seg.scan)
        begin
            if (seg.found)
            begin
                target_next = seg.target;
                w_deltas = seg.deltas;
                w_moved = '0;
                w_len = seg.len;
                w_step = '0;
                do_walk = 1'b1;
            end
            else
            begin
                // every remaining key equals the current colour
                target_next = rkg_pkg::KEY_W'(rkg_pkg::KEYS - 1);
                deltas_next = '0;
                moved_next = '0;
                len_next = '0;
                step_next = '0;
            end
        end

        if (do_walk)
        begin
            deltas_next = w_deltas;
            len_next = w_len;
            moved_next = w_moved;
            moved_next[best] = w_moved[best] + rkg_pkg::CHAN_W'(1);
            if (!w_deltas[best][rkg_pkg::DELTA_W-1] && (w_deltas[best] != '0))
                chans_next[best] = chans_reg[best] + rkg_pkg::CHAN_W'(1);
            else
                chans_next[best] = chans_reg[best] - rkg_pkg::CHAN_W'(1);
            step_next = w_step + rkg_pkg::LEN_W'(1);
        end

        result.colour = rkg_pkg::chans_to_colour(chans_next);
        result.index = band;
        result.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg <= rkg_pkg::colour_to_chans(rkg_pkg::KEY_RESET[0]);
            deltas_reg <= '0;
            moved_reg <= '0;
            len_reg <= '0;
            step_reg <= '0;
            target_reg <= '0;
            band_cnt_reg <= '0;
        end
        else if (step)
        begin
            chans_reg <= chans_next;
            deltas_reg <= deltas_next;
            moved_reg <= moved_next;
            len_reg <= len_next;
            step_reg <= step_next;
            target_reg <= target_next;
            band_cnt_reg <= band_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= len_reg)
        else $error("segment step ran past segment length");

    a_moved_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (rkg_pkg::LEN_W'(moved_reg[0]) + rkg_pkg::LEN_W'(moved_reg[1])
         + rkg_pkg::LEN_W'(moved_reg[2])) == step_reg)
        else $error("moved counts out of step with segment step");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        4'(target_reg) < 4'(rkg_pkg::KEYS))
        else $error("target key beyond key count");

    a_band_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (band_cnt_reg == '0))
        else $error("band counter did not wrap after last band");
`endif

endmodule

/* rtl/rgb_key_gradient_walker.sv */
// Gradient walker: one 12-bit RGB band colour per request on the req channel.
// Channels:
//   req  (sink)   - restart bit; 1 forces this request to give band 0.
//   band (source) - band_colour, band_index, last_band for each request.
//   cfg  (sink)   - key colour writes, index 0..5; always ready, other
//                   indexes are accepted and dropped.
// Band 0 is key 0; each later band steps one channel toward the next key that
// differs, if any. After band 57 (flagged last_band) the walk wraps to band 0.
// Latency: a result is valid the cycle after its request transfer.
// Throughput: one band per cycle. All segment search and channel selection
// sits between the walker state and the result register, so a request can
// be taken every cycle while band.ready is high.
// Stall: req.ready follows band.ready whenever a result is held; the held
// result stays put until its transfer.
// Reset: keys return to their default values, the walk is cleared and the
// next request gives band 0. No result is pending after reset.
module rgb_key_gradient_walker (
    input  logic       clk,
    input  logic       rst_n,
    rkg_req_if.sink    req,
    rkg_band_if.source band,
    rkg_cfg_if.sink    cfg
);

    rkg_pkg::key_bank_t keys;
    rkg_pkg::seg_t      seg;
    rkg_pkg::pos_t      pos;
    rkg_pkg::band_t     result;
    rkg_pkg::band_t     result_reg;
    logic               out_valid_reg;
    logic               accept;

    assign req.ready = !out_valid_reg || band.ready;
    assign accept = req.valid && req.ready;

    rkg_keys u_keys (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .keys  (keys)
    );

    rkg_seg_find u_seg_find (
        .keys (keys),
        .pos  (pos),
        .seg  (seg)
    );

    rkg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .restart (req.restart),
        .keys    (keys),
        .seg     (seg),
        .pos     (pos),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (band.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign band.valid = out_valid_reg;
    assign band.band_colour = result_reg.colour;
    assign band.band_index = result_reg.index;
    assign band.last_band = result_reg.last;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> band.valid)
        else $error("request transfer gave no result");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        band.valid |-> (band.last_band
            == (band.band_index == rkg_pkg::BAND_W'(rkg_pkg::BANDS - 1))))
        else $error("last_band does not match band_index");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !band.valid |-> req.ready)
        else $error("not ready while no result is held");
`endif

endmodule
